FILE: hdl/vpct_pkg.sv
// shared types and codes for the video port command transfer unit
// no dependencies
package vpct_pkg;

    localparam logic [2:0] CMD_CTRL_WORD  = 3'd0;
    localparam logic [2:0] CMD_CTRL_LONG  = 3'd1;
    localparam logic [2:0] CMD_DATA_WRITE = 3'd2;
    localparam logic [2:0] CMD_DATA_READ  = 3'd3;
    localparam logic [2:0] CMD_STATUS     = 3'd4;

    localparam logic [2:0] T_VRAM  = 3'd0;
    localparam logic [2:0] T_CRAM  = 3'd1;
    localparam logic [2:0] T_VSRAM = 3'd2;
    localparam logic [2:0] T_DATA  = 3'd3;
    localparam logic [2:0] T_BUS   = 3'd4;

    localparam logic [2:0] E_OK     = 3'd0;
    localparam logic [2:0] E_NOXFER = 3'd1;
    localparam logic [2:0] E_UNSUP  = 3'd2;
    localparam logic [2:0] E_BADCMD = 3'd3;
    localparam logic [2:0] E_ODD    = 3'd4;
    localparam logic [2:0] E_RANGE  = 3'd5;
    localparam logic [2:0] E_DIR    = 3'd6;

    localparam logic [3:0] CODE_VRAM_RD  = 4'd0;
    localparam logic [3:0] CODE_VRAM_WR  = 4'd1;
    localparam logic [3:0] CODE_CRAM_WR  = 4'd3;
    localparam logic [3:0] CODE_VSRAM_RD = 4'd4;
    localparam logic [3:0] CODE_VSRAM_WR = 4'd5;
    localparam logic [3:0] CODE_CRAM_RD  = 4'd8;

    localparam logic [15:0] CMD_MASK     = 16'hff0c;
    localparam logic [15:0] REG_TAG_MASK = 16'he000;
    localparam logic [15:0] REG_TAG      = 16'h8000;
    localparam logic [15:0] STATUS_BASE  = 16'h3608;
    localparam logic [15:0] STATUS_PAL   = 16'h0002;
    localparam logic [7:0]  SRC_MASK_LO  = 8'h7f;
    localparam logic [7:0]  SRC_MASK_HI  = 8'h3f;
    localparam logic [1:0]  FILL_MODE    = 2'b10;

    typedef struct packed {
        logic        bad;
        logic [15:0] addr;
        logic        dma;
        logic        fill;
        logic        copy;
        logic [2:0]  dst;
        logic [2:0]  src;
    } t_cmd_dec;

endpackage

FILE: hdl/vpct_ram.sv
// generic single-port synchronous ram, registered read
// no dependencies
module vpct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

FILE: hdl/vpct_cmd_decode.sv
// decodes a 32-bit port command into target, direction and transfer kind
// depends on vpct_pkg
module vpct_cmd_decode (
    input  logic [31:0]        i_cmd,
    input  logic [7:0]         i_dma_mode,
    output vpct_pkg::t_cmd_dec o_dec
);

    logic [3:0] code;
    logic [2:0] tgt;
    logic       rd;
    logic       known;
    logic [2:0] src_w;

    always_comb begin
        code  = {i_cmd[5:4], i_cmd[31:30]};
        tgt   = vpct_pkg::T_VRAM;
        rd    = 1'b0;
        known = 1'b1;
        unique case (code)
            vpct_pkg::CODE_VRAM_RD: begin
                tgt = vpct_pkg::T_VRAM;
                rd  = 1'b1;
            end
            vpct_pkg::CODE_VRAM_WR: begin
                tgt = vpct_pkg::T_VRAM;
            end
            vpct_pkg::CODE_CRAM_WR: begin
                tgt = vpct_pkg::T_CRAM;
            end
            vpct_pkg::CODE_VSRAM_RD: begin
                tgt = vpct_pkg::T_VSRAM;
                rd  = 1'b1;
            end
            vpct_pkg::CODE_VSRAM_WR: begin
                tgt = vpct_pkg::T_VSRAM;
            end
            vpct_pkg::CODE_CRAM_RD: begin
                tgt = vpct_pkg::T_CRAM;
                rd  = 1'b1;
            end
            default: begin
                known = 1'b0;
            end
        endcase
        o_dec.bad  = ((i_cmd[15:0] & vpct_pkg::CMD_MASK) != 16'h0000) || !known;
        o_dec.addr = {i_cmd[1:0], i_cmd[29:16]};
        o_dec.dma  = i_cmd[7];
        o_dec.fill = i_cmd[7] && (i_dma_mode[7:6] == vpct_pkg::FILL_MODE);
        o_dec.copy = i_cmd[7] && !o_dec.fill;
        if (i_cmd[6]) begin
            src_w = vpct_pkg::T_VRAM;
        end else if (o_dec.copy) begin
            src_w = vpct_pkg::T_BUS;
        end else begin
            src_w = vpct_pkg::T_DATA;
        end
        o_dec.src = rd ? tgt : src_w;
        o_dec.dst = rd ? src_w : tgt;
    end

endmodule

FILE: hdl/video_port_command_transfer_unit.sv
// top level: port sequencer over video, colour and scroll memories
// depends on vpct_pkg, vpct_ram, vpct_cmd_decode
// control and status requests are answered straight into the output register; a data read passes S_RDATA first
// fill writes one word per S_FILL step; copy between any memories runs S_COPY_RD then S_COPY_WR for each word
// throughput: one request at a time, next request taken once the unit is idle and the result slot is free
// reset: synchronous; a clearing pass over all VIDEO_WORDS addresses zeroes all memories first
module video_port_command_transfer_unit #(
    parameter int VIDEO_WORDS    = 65536,
    parameter int COLOUR_WORDS   = 64,
    parameter int SCROLL_WORDS   = 40,
    parameter int REGISTER_COUNT = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,  // command[2:0], value[34:3], zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // read_word[15:0], error_code[18:16], zero pad
);

    localparam int VAW = $clog2(VIDEO_WORDS);
    localparam int CAW = $clog2(COLOUR_WORDS);
    localparam int SAW = $clog2(SCROLL_WORDS);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RDATA, S_COPY_RD, S_COPY_WR, S_FILL
    } t_state;

    t_state      r_state, n_state;
    logic [VAW-1:0] r_clr, n_clr;
    logic [7:0]  r_regs [REGISTER_COUNT];
    logic        r_pend, n_pend;
    logic [15:0] r_high, n_high;
    logic        r_act, n_act;
    logic [2:0]  r_dst, n_dst;
    logic [2:0]  r_src, n_src;
    logic [17:0] r_addr, n_addr;
    logic [15:0] r_len, n_len;
    logic        r_dma, n_dma;
    logic        r_fill, n_fill;
    logic [15:0] r_k, n_k;
    logic [15:0] r_cnt, n_cnt;
    logic [2:0]  r_cp_src, n_cp_src;
    logic [2:0]  r_cp_dst, n_cp_dst;
    logic [22:0] r_cp_sw, n_cp_sw;
    logic [14:0] r_cp_dw, n_cp_dw;
    logic        r_cp_odd, n_cp_odd;
    logic [15:0] r_data, n_data;
    logic [2:0]  r_rd_tgt, n_rd_tgt;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_word, n_out_word;
    logic [2:0]  r_out_err, n_out_err;

    logic        accept;
    logic [2:0]  cmd;
    logic [31:0] val;
    logic [15:0] lo;
    logic [31:0] dec_in;
    vpct_pkg::t_cmd_dec dec;
    logic        do_long;
    logic        finish;
    logic [15:0] fin_word;
    logic [2:0]  fin_err;
    logic [2:0]  e;
    logic [2:0]  e2;
    logic        acc_we;
    logic [2:0]  acc_tgt;
    logic [23:0] acc_word;
    logic [15:0] acc_wdata;
    logic [15:0] rdata;
    logic        rw_a_we, rw_b_we;
    logic [4:0]  rw_a_idx, rw_b_idx;
    logic [7:0]  rw_a_val, rw_b_val;
    logic        clearing;
    logic        v_we, c_we, s_we;
    logic [15:0] v_q, c_q, s_q;
    logic [15:0] mem_wdata;
    logic [7:0]  src_mask;

    function automatic logic [2:0] f_locate(logic [2:0] tgt, logic odd, logic [23:0] word);
        logic [2:0] r;
        r = vpct_pkg::E_OK;
        if (tgt == vpct_pkg::T_BUS) begin
            r = vpct_pkg::E_UNSUP;
        end else if (tgt != vpct_pkg::T_VRAM && tgt != vpct_pkg::T_CRAM
                     && tgt != vpct_pkg::T_VSRAM) begin
            r = vpct_pkg::E_DIR;
        end else if (odd) begin
            r = vpct_pkg::E_ODD;
        end else if ((tgt == vpct_pkg::T_VRAM && word >= 24'(VIDEO_WORDS))
                     || (tgt == vpct_pkg::T_CRAM && word >= 24'(COLOUR_WORDS))
                     || (tgt == vpct_pkg::T_VSRAM && word >= 24'(SCROLL_WORDS))) begin
            r = vpct_pkg::E_RANGE;
        end
        return r;
    endfunction

    function automatic logic [2:0] f_reg_err(logic [15:0] w);
        logic [2:0] r;
        r = vpct_pkg::E_OK;
        if ((w & vpct_pkg::REG_TAG_MASK) != vpct_pkg::REG_TAG) begin
            r = vpct_pkg::E_BADCMD;
        end else if ({1'b0, w[12:8]} >= 6'(REGISTER_COUNT)) begin
            r = vpct_pkg::E_RANGE;
        end
        return r;
    endfunction

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign cmd             = i_s_axis_tdata[2:0];
    assign val             = i_s_axis_tdata[34:3];
    assign lo              = val[15:0];
    assign dec_in          = (cmd == vpct_pkg::CMD_CTRL_WORD) ? {r_high, lo} : val;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_err, r_out_word};
    assign src_mask        = r_regs[23][7] ? vpct_pkg::SRC_MASK_HI : vpct_pkg::SRC_MASK_LO;

    vpct_cmd_decode u_dec (
        .i_cmd      (dec_in),
        .i_dma_mode (r_regs[23]),
        .o_dec      (dec)
    );

    always_comb begin
        case (r_rd_tgt)
            vpct_pkg::T_VRAM:  rdata = v_q;
            vpct_pkg::T_CRAM:  rdata = c_q;
            vpct_pkg::T_VSRAM: rdata = s_q;
            default:           rdata = 16'h0000;
        endcase
    end

    always_comb begin
        n_state = r_state;   n_clr = r_clr;       n_pend = r_pend;     n_high = r_high;
        n_act = r_act;       n_dst = r_dst;       n_src = r_src;       n_addr = r_addr;
        n_len = r_len;       n_dma = r_dma;       n_fill = r_fill;     n_k = r_k;
        n_cnt = r_cnt;       n_cp_src = r_cp_src; n_cp_dst = r_cp_dst; n_cp_sw = r_cp_sw;
        n_cp_dw = r_cp_dw;   n_cp_odd = r_cp_odd; n_data = r_data;     n_rd_tgt = r_rd_tgt;
        do_long = 1'b0;      finish = 1'b0;       fin_word = 16'h0000; fin_err = vpct_pkg::E_OK;
        e = vpct_pkg::E_OK;  e2 = vpct_pkg::E_OK;
        acc_we = 1'b0;       acc_tgt = r_src;     acc_word = {7'b0, r_addr[17:1]};
        acc_wdata = r_data;
        rw_a_we = 1'b0;      rw_a_idx = lo[12:8]; rw_a_val = lo[7:0];
        rw_b_we = 1'b0;      rw_b_idx = lo[12:8]; rw_b_val = lo[7:0];
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == VAW'(VIDEO_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    finish = 1'b1;
                    case (cmd)
                        vpct_pkg::CMD_CTRL_WORD: begin
                            if (r_pend) begin
                                n_pend  = 1'b0;
                                do_long = 1'b1;
                            end else if ((lo & vpct_pkg::REG_TAG_MASK) == vpct_pkg::REG_TAG) begin
                                fin_err = f_reg_err(lo);
                                rw_b_we = (fin_err == vpct_pkg::E_OK);
                            end else begin
                                n_pend = 1'b1;
                                n_high = lo;
                            end
                        end
                        vpct_pkg::CMD_CTRL_LONG: begin
                            if ((val[15:0] & vpct_pkg::CMD_MASK) == 16'h0000) begin
                                do_long = 1'b1;
                            end else begin
                                e        = f_reg_err(val[31:16]);
                                rw_a_idx = val[28:24];
                                rw_a_val = val[23:16];
                                rw_a_we  = (e == vpct_pkg::E_OK);
                                e2       = f_reg_err(lo);
                                rw_b_we  = rw_a_we && (e2 == vpct_pkg::E_OK);
                                fin_err  = (e != vpct_pkg::E_OK) ? e : e2;
                            end
                        end
                        vpct_pkg::CMD_DATA_WRITE: begin
                            if (!r_act) begin
                                fin_err = vpct_pkg::E_NOXFER;
                            end else if (r_dma && r_fill) begin
                                if (r_len == 16'h0000) begin
                                    n_act = 1'b0;
                                end else begin
                                    finish  = 1'b0;
                                    n_data  = lo;
                                    n_k     = 16'h0000;
                                    n_state = S_FILL;
                                end
                            end else if (!r_dma) begin
                                fin_err = f_locate(r_dst, r_addr[0], {7'b0, r_addr[17:1]});
                                if (fin_err == vpct_pkg::E_OK) begin
                                    acc_we    = 1'b1;
                                    acc_tgt   = r_dst;
                                    acc_wdata = lo;
                                    n_addr    = r_addr + {10'b0, r_regs[15]};
                                end
                            end else begin
                                fin_err = vpct_pkg::E_UNSUP;
                            end
                        end
                        vpct_pkg::CMD_DATA_READ: begin
                            if (!r_act) begin
                                fin_err = vpct_pkg::E_NOXFER;
                            end else if (r_dma) begin
                                fin_err = vpct_pkg::E_UNSUP;
                            end else if (r_dst != vpct_pkg::T_DATA) begin
                                fin_err = vpct_pkg::E_DIR;
                            end else begin
                                fin_err = f_locate(r_src, r_addr[0], {7'b0, r_addr[17:1]});
                                if (fin_err == vpct_pkg::E_OK) begin
                                    finish   = 1'b0;
                                    n_rd_tgt = r_src;
                                    n_state  = S_RDATA;
                                end
                            end
                        end
                        vpct_pkg::CMD_STATUS: begin
                            fin_word = vpct_pkg::STATUS_BASE
                                     | (r_regs[1][3] ? vpct_pkg::STATUS_PAL : 16'h0000);
                        end
                        default: begin
                            fin_err = vpct_pkg::E_BADCMD;
                        end
                    endcase
                    if (do_long) begin
                        if (dec.bad) begin
                            fin_err = vpct_pkg::E_BADCMD;
                        end else begin
                            n_act = 1'b0;
                            if (dec.copy) begin
                                if (dec.src == vpct_pkg::T_BUS || dec.dst == vpct_pkg::T_BUS) begin
                                    fin_err = vpct_pkg::E_UNSUP;
                                end else if ({r_regs[20], r_regs[19]} != 16'h0000) begin
                                    finish   = 1'b0;
                                    n_cp_src = dec.src;
                                    n_cp_dst = dec.dst;
                                    n_cp_sw  = {r_regs[23][6:0] & src_mask[6:0],
                                                r_regs[22], r_regs[21]};
                                    n_cp_dw  = dec.addr[15:1];
                                    n_cp_odd = dec.addr[0];
                                    n_cnt    = {r_regs[20], r_regs[19]};
                                    n_k      = 16'h0000;
                                    n_state  = S_COPY_RD;
                                end
                            end else begin
                                n_act  = 1'b1;
                                n_dst  = dec.dst;
                                n_src  = dec.src;
                                n_addr = {2'b00, dec.addr};
                                n_len  = {r_regs[20], r_regs[19]};
                                n_dma  = dec.dma;
                                n_fill = dec.fill;
                            end
                        end
                    end
                end
            end
            S_RDATA: begin
                finish   = 1'b1;
                fin_word = rdata;
                n_addr   = r_addr + {10'b0, r_regs[15]};
            end
            S_COPY_RD: begin
                acc_tgt  = r_cp_src;
                acc_word = {1'b0, r_cp_sw} + {8'b0, r_k};
                e        = f_locate(r_cp_src, 1'b0, acc_word);
                if (e != vpct_pkg::E_OK) begin
                    finish  = 1'b1;
                    fin_err = e;
                end else begin
                    n_rd_tgt = r_cp_src;
                    n_state  = S_COPY_WR;
                end
            end
            S_COPY_WR: begin
                acc_tgt   = r_cp_dst;
                acc_word  = {9'b0, r_cp_dw} + {8'b0, r_k};
                acc_wdata = rdata;
                e         = f_locate(r_cp_dst, r_cp_odd, acc_word);
                if (e != vpct_pkg::E_OK) begin
                    finish  = 1'b1;
                    fin_err = e;
                end else begin
                    acc_we = 1'b1;
                    if (r_k == r_cnt - 16'd1) begin
                        finish = 1'b1;
                    end else begin
                        n_k     = r_k + 16'd1;
                        n_state = S_COPY_RD;
                    end
                end
            end
            S_FILL: begin
                acc_tgt  = r_dst;
                acc_word = {7'b0, r_addr[17:1]} + {8'b0, r_k};
                e        = f_locate(r_dst, r_addr[0], acc_word);
                if (e != vpct_pkg::E_OK) begin
                    finish  = 1'b1;
                    fin_err = e;
                end else begin
                    acc_we = 1'b1;
                    if (r_k == r_len - 16'd1) begin
                        finish = 1'b1;
                        n_act  = 1'b0;
                    end else begin
                        n_k = r_k + 16'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (finish) begin
            n_state = S_IDLE;
        end
        n_out_valid = finish ? 1'b1 : (r_out_valid && !i_m_axis_tready);
        n_out_word  = finish ? ((fin_err == vpct_pkg::E_OK) ? fin_word : 16'h0000) : r_out_word;
        n_out_err   = finish ? fin_err : r_out_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;  r_clr <= '0;       r_pend <= 1'b0;   r_high <= '0;
            r_act <= 1'b0;       r_dst <= '0;       r_src <= '0;      r_addr <= '0;
            r_len <= '0;         r_dma <= 1'b0;     r_fill <= 1'b0;   r_k <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_regs[i] <= 8'h00;
            end
        end else begin
            r_state <= n_state;  r_clr <= n_clr;    r_pend <= n_pend; r_high <= n_high;
            r_act <= n_act;      r_dst <= n_dst;    r_src <= n_src;   r_addr <= n_addr;
            r_len <= n_len;      r_dma <= n_dma;    r_fill <= n_fill; r_k <= n_k;
            r_out_valid <= n_out_valid;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                if (rw_b_we && rw_b_idx == 5'(i)) begin
                    r_regs[i] <= rw_b_val;
                end else if (rw_a_we && rw_a_idx == 5'(i)) begin
                    r_regs[i] <= rw_a_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;       r_cp_src <= n_cp_src; r_cp_dst <= n_cp_dst;
        r_cp_sw <= n_cp_sw;   r_cp_dw <= n_cp_dw;   r_cp_odd <= n_cp_odd;
        r_data <= n_data;     r_rd_tgt <= n_rd_tgt;
        r_out_word <= n_out_word;
        r_out_err <= n_out_err;
    end

    // memory ports, zero written during the clearing pass
    assign clearing  = (r_state == S_CLEAR);
    assign mem_wdata = clearing ? 16'h0000 : acc_wdata;
    assign v_we = clearing || (acc_we && acc_tgt == vpct_pkg::T_VRAM);
    assign c_we = clearing ? (r_clr < VAW'(COLOUR_WORDS))
                           : (acc_we && acc_tgt == vpct_pkg::T_CRAM);
    assign s_we = clearing ? (r_clr < VAW'(SCROLL_WORDS))
                           : (acc_we && acc_tgt == vpct_pkg::T_VSRAM);

    vpct_ram #(.WIDTH(16), .DEPTH(VIDEO_WORDS)) u_vram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_addr  (clearing ? r_clr : acc_word[VAW-1:0]),
        .i_wdata (mem_wdata),
        .o_rdata (v_q)
    );

    vpct_ram #(.WIDTH(16), .DEPTH(COLOUR_WORDS)) u_cram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_addr  (clearing ? r_clr[CAW-1:0] : acc_word[CAW-1:0]),
        .i_wdata (mem_wdata),
        .o_rdata (c_q)
    );

    vpct_ram #(.WIDTH(16), .DEPTH(SCROLL_WORDS)) u_vsram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_addr  (clearing ? r_clr[SAW-1:0] : acc_word[SAW-1:0]),
        .i_wdata (mem_wdata),
        .o_rdata (s_q)
    );

endmodule
